>>> hw/rtl/bab_pkg.sv
// Shared types, codes and sizes of the block allocation bitmap.
package bab_pkg;

    localparam int DEF_MAX_BLOCKS   = 1024;
    localparam int RESET_BLOCKS     = 1024;
    localparam int WORD_W           = 32;
    localparam int WORD_SH          = 5;
    localparam int CFG_W            = 11;
    localparam int FUNC_W           = 2;
    localparam int INDEX_W          = 10;
    localparam int STATUS_W         = 2;
    localparam int FOUND_W          = 10;
    localparam int COUNT_W          = 11;

    localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_block;
        logic [COUNT_W-1:0]  free_count;
        logic [COUNT_W-1:0]  first_free;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_ISSUE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic exec;
        logic scan_init;
        logic scan_step;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic need_scan;
        logic scan_done;
        logic rsp_free;
    } sts_t;

endpackage

>>> hw/rtl/bab_ctrl.sv
// Controller state machine of the block allocation bitmap.
module bab_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  logic          cfg_we,
    input  bab_pkg::sts_t sts,
    output bab_pkg::cmd_t cmd
);

    bab_pkg::state_t state_reg;
    bab_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bab_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            bab_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = bab_pkg::ST_IDLE;
                end
            end
            bab_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = bab_pkg::ST_EXEC;
                end
            end
            bab_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.need_scan)
                begin
                    state_next = bab_pkg::ST_SCAN_ISSUE;
                end
                else
                begin
                    state_next = bab_pkg::ST_RESP;
                end
            end
            bab_pkg::ST_SCAN_ISSUE:
            begin
                cmd.scan_init = 1'b1;
                state_next    = bab_pkg::ST_SCAN;
            end
            bab_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = bab_pkg::ST_RESP;
                end
            end
            bab_pkg::ST_RESP:
            begin
                if (sts.rsp_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = bab_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bab_pkg::ST_CLEAR;
            end
        endcase
        // A write of the block count formats the disk, so the map is swept again.
        if (cfg_we)
        begin
            state_next = bab_pkg::ST_CLEAR;
        end
    end

endmodule

>>> hw/rtl/bab_dp.sv
// Datapath of the block allocation bitmap: word-wide map memory, counters and scan logic.
module bab_dp #(
    parameter int MAX_BLOCKS = bab_pkg::DEF_MAX_BLOCKS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bab_pkg::cmd_t             cmd,
    output bab_pkg::sts_t             sts,
    input  bab_pkg::req_t             req,
    input  logic                      cfg_we,
    input  logic [bab_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      rsp_ready,
    output logic                      rsp_valid,
    output bab_pkg::rsp_t             rsp
);

    localparam int WORD_W  = bab_pkg::WORD_W;
    localparam int WORD_SH = bab_pkg::WORD_SH;
    localparam int ROWS    = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BLK_W   = ROW_W + WORD_SH;
    localparam int CW      = (BLK_W + 1 > bab_pkg::CFG_W) ? BLK_W + 1 : bab_pkg::CFG_W;
    localparam int RST_N   = (bab_pkg::RESET_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS
                                                                 : bab_pkg::RESET_BLOCKS;

    logic [WORD_W-1:0] map_mem [ROWS];
    logic [WORD_W-1:0] rd_word_reg;
    logic [ROW_W-1:0]  rd_addr;
    logic [ROW_W-1:0]  wr_addr;
    logic              wr_en;
    logic [WORD_W-1:0] wr_word;

    logic [bab_pkg::FUNC_W-1:0]   func_reg,   func_next;
    logic [CW-1:0]                idx_reg,    idx_next;
    logic [CW-1:0]                n_reg,      n_next;
    logic [CW-1:0]                free_reg,   free_next;
    logic [CW-1:0]                low_reg,    low_next;
    logic [bab_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]                found_reg,  found_next;
    logic [ROW_W-1:0]             scan_row_reg, scan_row_next;
    logic [ROW_W-1:0]             clr_row_reg,  clr_row_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    bab_pkg::rsp_t                rsp_reg,    rsp_next;

    logic [CW-1:0]      in_idx;
    logic [CW-1:0]      cfg_n;
    logic [ROW_W-1:0]   idx_row;
    logic [WORD_SH-1:0] bit_sel;
    logic [WORD_W-1:0]  bit_mask;
    logic               cur_bit;
    logic               oor;
    logic               need_scan;

    logic [WORD_W-1:0]  cand;
    logic [WORD_SH-1:0] pe;
    logic               hit;
    logic [CW-1:0]      row_base;
    logic               last_row;
    logic               scan_done;
    logic [CW-1:0]      scan_pos;
    logic [CW-1:0]      scan_res;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_word;
        end
        rd_word_reg <= map_mem[rd_addr];
    end

    assign in_idx   = CW'(req.block_index);
    assign cfg_n    = (CW'(cfg_wdata) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(cfg_wdata);
    assign idx_row  = idx_reg[BLK_W-1:WORD_SH];
    assign bit_sel  = idx_reg[WORD_SH-1:0];
    assign bit_mask = WORD_W'(1) << bit_sel;
    assign cur_bit  = rd_word_reg[bit_sel];
    assign oor      = idx_reg >= n_reg;

    // A block is a candidate when it is free, at or after the start index and on the disk.
    always_comb
    begin
        logic [BLK_W-1:0] blk;
        cand = '0;
        blk  = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            blk     = {scan_row_reg, WORD_SH'(b)};
            cand[b] = !rd_word_reg[b] && (CW'(blk) >= idx_reg) && (CW'(blk) < n_reg);
        end
        pe = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                pe = WORD_SH'(b);
            end
        end
    end

    assign hit       = |cand;
    assign row_base  = CW'({scan_row_reg, {WORD_SH{1'b0}}});
    assign last_row  = (row_base + CW'(WORD_W)) >= n_reg;
    assign scan_done = hit || last_row;
    assign scan_pos  = CW'({scan_row_reg, pe});
    assign scan_res  = hit ? scan_pos : n_reg;

    always_comb
    begin
        func_next      = func_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        free_next      = free_reg;
        low_next       = low_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        scan_row_next  = scan_row_reg;
        clr_row_next   = clr_row_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        wr_en          = 1'b0;
        wr_addr        = idx_row;
        wr_word        = rd_word_reg;
        rd_addr        = scan_row_reg;
        need_scan      = 1'b0;

        if (cmd.accept)
        begin
            func_next = req.func;
            idx_next  = in_idx;
            rd_addr   = in_idx[BLK_W-1:WORD_SH];
        end

        if (cmd.clr_step)
        begin
            wr_en        = 1'b1;
            wr_addr      = clr_row_reg;
            wr_word      = '0;
            clr_row_next = clr_row_reg + ROW_W'(1);
        end

        if (cmd.exec)
        begin
            status_next   = bab_pkg::STATUS_OK;
            found_next    = '0;
            scan_row_next = idx_row;
            if (oor)
            begin
                status_next = bab_pkg::STATUS_RANGE;
            end
            else
            begin
                case (func_reg)
                    bab_pkg::FUNC_CHECK:
                    begin
                        if (!cur_bit)
                        begin
                            status_next = bab_pkg::STATUS_FREE;
                        end
                    end
                    bab_pkg::FUNC_MARK:
                    begin
                        if (!cur_bit)
                        begin
                            wr_en   = 1'b1;
                            wr_word = rd_word_reg | bit_mask;
                            if (free_reg != '0)
                            begin
                                free_next = free_reg - CW'(1);
                            end
                        end
                        // Everything below the first free block is used, so the
                        // rescan can start at the block just taken.
                        if (idx_reg == low_reg)
                        begin
                            need_scan = 1'b1;
                        end
                    end
                    bab_pkg::FUNC_FREE:
                    begin
                        if (cur_bit)
                        begin
                            wr_en     = 1'b1;
                            wr_word   = rd_word_reg & ~bit_mask;
                            free_next = free_reg + CW'(1);
                        end
                        if (idx_reg < low_reg)
                        begin
                            low_next = idx_reg;
                        end
                    end
                    bab_pkg::FUNC_FIND:
                    begin
                        if (idx_reg < low_reg)
                        begin
                            if (low_reg < n_reg)
                            begin
                                found_next = low_reg;
                            end
                            else
                            begin
                                status_next = bab_pkg::STATUS_NONE;
                            end
                        end
                        else
                        begin
                            need_scan = 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = bab_pkg::STATUS_OK;
                    end
                endcase
            end
        end

        if (cmd.scan_init)
        begin
            rd_addr = scan_row_reg;
        end

        if (cmd.scan_step)
        begin
            rd_addr       = scan_row_reg + ROW_W'(1);
            scan_row_next = scan_row_reg + ROW_W'(1);
            if (scan_done)
            begin
                if (func_reg == bab_pkg::FUNC_MARK)
                begin
                    low_next = scan_res;
                end
                else if (hit)
                begin
                    found_next = scan_pos;
                end
                else
                begin
                    status_next = bab_pkg::STATUS_NONE;
                end
            end
        end

        if (cmd.res_load)
        begin
            rsp_next.status      = status_reg;
            rsp_next.found_block = found_reg[bab_pkg::FOUND_W-1:0];
            rsp_next.free_count  = free_reg[bab_pkg::COUNT_W-1:0];
            rsp_next.first_free  = low_reg[bab_pkg::COUNT_W-1:0];
            rsp_valid_next       = 1'b1;
        end

        if (cfg_we)
        begin
            n_next       = cfg_n;
            free_next    = cfg_n;
            low_next     = '0;
            clr_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CW'(RST_N);
            free_reg      <= CW'(RST_N);
            low_reg       <= '0;
            clr_row_reg   <= '0;
            scan_row_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            free_reg      <= free_next;
            low_reg       <= low_next;
            clr_row_reg   <= clr_row_next;
            scan_row_reg  <= scan_row_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rsp_reg    <= rsp_next;
    end

    assign sts.clr_last  = clr_row_reg == ROW_W'(ROWS - 1);
    assign sts.need_scan = need_scan;
    assign sts.scan_done = scan_done;
    assign sts.rsp_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/block_allocation_bitmap.sv
// Block allocation bitmap top level: request and response channels, block count register.
//
// Keeps one used/free bit per block in a map memory of 32-bit words, together with
// the free-block count and the lowest free index. After reset, and after every write of
// the block count (which formats the disk), the map is swept clean one word per cycle,
// during which no request is taken. Check, free, mark of a block other than the first
// free one, find from below the first free block and any request out of range need no
// scan: the execute state goes straight to the response state, which loads the output
// register once it is free. Mark of the first free block, and find from an index at or
// past the first free block, scan the map one word per cycle from the word of the
// index until a free block is hit or the last word of the disk is read. One request is
// worked on at a time; the next request is taken while a finished response still waits
// in the output register.
module block_allocation_bitmap #(
    parameter int MAX_BLOCKS = bab_pkg::DEF_MAX_BLOCKS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  bab_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output bab_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic [bab_pkg::CFG_W-1:0] cfg_wdata
);

    bab_pkg::cmd_t cmd;
    bab_pkg::sts_t sts;

    bab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cfg_we    (cfg_we),
        .sts       (sts),
        .cmd       (cmd)
    );

    bab_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

>>> sim/block_allocation_bitmap_test.sv
// Self-checking testbench for the block allocation bitmap: directed, random and stall tests.
`timescale 1ns / 1ps

module block_allocation_bitmap_test;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_ready;
    bab_pkg::req_t             req;
    logic                      rsp_valid;
    logic                      rsp_ready;
    bab_pkg::rsp_t             rsp;
    logic                      cfg_we;
    logic [bab_pkg::CFG_W-1:0] cfg_wdata;

    // Own copy of the allocator state, updated at each request transfer.
    bit    used_bits [bab_pkg::DEF_MAX_BLOCKS];
    int    spare_blocks;
    int    lowest_free;
    int    disk_size;

    bab_pkg::rsp_t awaited_rsp [$];
    int    error_count;
    bit    sender_idles;
    bit    receiver_idles;
    int    hold_left;
    int    stall_left;

    block_allocation_bitmap dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int live_blocks();
        return (disk_size > bab_pkg::DEF_MAX_BLOCKS) ? bab_pkg::DEF_MAX_BLOCKS : disk_size;
    endfunction

    function automatic void wipe_map(input int size);
        disk_size = size;
        for (int i = 0; i < bab_pkg::DEF_MAX_BLOCKS; i++)
        begin
            used_bits[i] = 1'b0;
        end
        spare_blocks = live_blocks();
        lowest_free = 0;
    endfunction

    function automatic int first_free_from(input int start, input int n);
        for (int i = start; i < n; i++)
        begin
            if (!used_bits[i])
                return i;
        end
        return n;
    endfunction

    // Applies one request to the local map and returns the response it should give.
    function automatic bab_pkg::rsp_t apply_request(input bab_pkg::req_t r);
        bab_pkg::rsp_t res;
        int   n;
        int   idx;
        int   f;
        n = live_blocks();
        idx = r.block_index;
        res = '0;
        res.status = bab_pkg::STATUS_OK;
        if (idx >= n)
        begin
            res.status = bab_pkg::STATUS_RANGE;
        end
        else
        begin
            case (r.func)
                bab_pkg::FUNC_CHECK:
                begin
                    if (!used_bits[idx])
                        res.status = bab_pkg::STATUS_FREE;
                end
                bab_pkg::FUNC_MARK:
                begin
                    if (!used_bits[idx])
                    begin
                        used_bits[idx] = 1'b1;
                        if (spare_blocks > 0)
                            spare_blocks--;
                    end
                    if (idx == lowest_free)
                        lowest_free = first_free_from(0, n);
                end
                bab_pkg::FUNC_FREE:
                begin
                    // Freeing a block that is already free leaves the count alone.
                    if (used_bits[idx])
                    begin
                        used_bits[idx] = 1'b0;
                        spare_blocks++;
                    end
                    if (idx < lowest_free)
                        lowest_free = idx;
                end
                default:
                begin
                    f = (idx < lowest_free) ? lowest_free : first_free_from(idx, n);
                    if (f >= n)
                        res.status = bab_pkg::STATUS_NONE;
                    else
                        res.found_block = f[bab_pkg::FOUND_W-1:0];
                end
            endcase
        end
        res.free_count = spare_blocks[bab_pkg::COUNT_W-1:0];
        res.first_free = lowest_free[bab_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // Offers one request and waits for its transfer; valid is left high on return.
    task automatic send_request(input logic [bab_pkg::FUNC_W-1:0] func, input int idx);
        bab_pkg::req_t item;
        item.func = func;
        item.block_index = idx[bab_pkg::INDEX_W-1:0];
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!req_ready);
        awaited_rsp.push_back(apply_request(item));
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Writing the block count formats the disk, so it is only done with nothing in flight.
    task automatic format_disk(input int size);
        drain_responses();
        cfg_we <= 1'b1;
        cfg_wdata <= size[bab_pkg::CFG_W-1:0];
        @(posedge clk);
        wipe_map(size);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_index(input int n);
        int roll;
        roll = $urandom_range(0, 99);
        if (n == 0 || roll < 8)
            return $urandom_range(0, bab_pkg::DEF_MAX_BLOCKS - 1);
        else if (roll < 20 && lowest_free < n)
            return lowest_free;
        else
            return $urandom_range(0, n - 1);
    endfunction

    function automatic logic [bab_pkg::FUNC_W-1:0] pick_func();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return bab_pkg::FUNC_MARK;
        else if (roll < 55)
            return bab_pkg::FUNC_FREE;
        else if (roll < 75)
            return bab_pkg::FUNC_CHECK;
        else
            return bab_pkg::FUNC_FIND;
    endfunction

    task automatic test_reset_state();
        send_request(bab_pkg::FUNC_CHECK, 0);
        send_request(bab_pkg::FUNC_FIND, 0);
        send_request(bab_pkg::FUNC_MARK, 0);
        send_request(bab_pkg::FUNC_MARK, 0);
        send_request(bab_pkg::FUNC_CHECK, 0);
        send_request(bab_pkg::FUNC_FIND, 0);
        send_request(bab_pkg::FUNC_MARK, 1023);
        send_request(bab_pkg::FUNC_CHECK, 1023);
        send_request(bab_pkg::FUNC_FIND, 1023);
        send_request(bab_pkg::FUNC_FREE, 1023);
        send_request(bab_pkg::FUNC_FREE, 1023);
        send_request(bab_pkg::FUNC_FREE, 0);
        send_request(bab_pkg::FUNC_FIND, 1023);
    endtask

    task automatic test_single_block();
        format_disk(1);
        send_request(bab_pkg::FUNC_CHECK, 0);
        send_request(bab_pkg::FUNC_MARK, 0);
        send_request(bab_pkg::FUNC_FIND, 0);
        send_request(bab_pkg::FUNC_CHECK, 1023);
        send_request(bab_pkg::FUNC_MARK, 5);
        send_request(bab_pkg::FUNC_FREE, 0);
        send_request(bab_pkg::FUNC_FIND, 0);
    endtask

    task automatic test_empty_and_oversized_disk();
        format_disk(0);
        send_request(bab_pkg::FUNC_CHECK, 0);
        send_request(bab_pkg::FUNC_FIND, 0);
        format_disk(2047);
        send_request(bab_pkg::FUNC_MARK, 1023);
        send_request(bab_pkg::FUNC_FIND, 512);
    endtask

    task automatic test_random_traffic();
        int sizes [8] = '{8, 1024, 37, 1, 200, 16, 2047, 64};
        foreach (sizes[s])
        begin
            format_disk(sizes[s]);
            repeat (200)
                send_request(pick_func(), pick_index(live_blocks()));
        end
    endtask

    // The receiver holds off while requests keep coming, so the block fills and stalls.
    task automatic test_output_backpressure();
        format_disk(24);
        hold_left = 150;
        repeat (30)
            send_request(pick_func(), pick_index(live_blocks()));
    endtask

    task automatic test_full_rate();
        format_disk(12);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        repeat (100)
            send_request(pick_func(), pick_index(live_blocks()));
    endtask

    initial
    begin
        rsp_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_response
        bab_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $display("%0t: unexpected response: status %0d found %0d count %0d first %0d",
                         $realtime, rsp.status, rsp.found_block, rsp.free_count,
                         rsp.first_free);
                error_count++;
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp !== want)
                begin
                    $display("%0t: expected status %0d found %0d count %0d first %0d", $realtime,
                             want.status, want.found_block, want.free_count, want.first_free);
                    $display("%0t: actual   status %0d found %0d count %0d first %0d", $realtime,
                             rsp.status, rsp.found_block, rsp.free_count, rsp.first_free);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        error_count = 0;
        hold_left = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        wipe_map(bab_pkg::RESET_BLOCKS);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_single_block();
        test_empty_and_oversized_disk();
        test_random_traffic();
        test_output_backpressure();
        test_full_rate();

        drain_responses();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
